// ===== sv/lede_pkg.sv =====
// ============================================================================
// lede_pkg
// Shared types and constants for the line editor with echo and quit match.
// ============================================================================
package lede_pkg;

   localparam int LINE_LEN_DEF = 32;
   localparam int BYTE_W       = 8;

   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7f;
   localparam logic [BYTE_W-1:0] CHAR_Q     = 8'h71;
   localparam logic [BYTE_W-1:0] CHAR_U     = 8'h75;
   localparam logic [BYTE_W-1:0] CHAR_I     = 8'h69;
   localparam logic [BYTE_W-1:0] CHAR_T     = 8'h74;
   localparam logic [BYTE_W-1:0] CHAR_E     = 8'h65;
   localparam logic [BYTE_W-1:0] CHAR_X     = 8'h78;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_BS1,
      ST_BS2,
      ST_BS3,
      ST_CR,
      ST_CR_LF,
      ST_ECHO_END,
      ST_ECHO_CHAR,
      ST_RD,
      ST_RD_EMIT,
      ST_CRLF_CR,
      ST_CRLF_LF
   } state_type;

   typedef enum logic [2:0] {
      SEL_BS,
      SEL_SPACE,
      SEL_CR,
      SEL_LF,
      SEL_RX,
      SEL_MEM
   } emit_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         store;
      logic         erase;
      logic         clear_line;
      logic         halt;
      logic         idx_clear;
      logic         rd;
      logic         emit;
      emit_sel_type sel;
      logic         last;
      logic         quit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_erase;
      logic is_cr;
      logic is_end;
      logic fill_zero;
      logic fill_full;
      logic quit_match;
      logic idx_done;
      logic halted;
      logic slot_free;
   } status_type;

endpackage

// ===== sv/lede_req_if.sv =====
// ============================================================================
// lede_req_if
// Valid/ready channel that carries one received byte per word.
// ============================================================================
interface lede_req_if;
   logic                         valid;
   logic                         ready;
   logic [lede_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/lede_rsp_if.sv =====
// ============================================================================
// lede_rsp_if
// Valid/ready channel that carries one transmit byte and its marks per word.
// ============================================================================
interface lede_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lede_pkg::BYTE_W-1:0]  tx_byte;
   logic                         last;
   logic                         quit_seen;

   modport source (output valid, output tx_byte, output last, output quit_seen,
                   input ready);
   modport sink   (input valid, input tx_byte, input last, input quit_seen,
                   output ready);
endinterface

// ===== sv/lede_ctrl.sv =====
// ============================================================================
// lede_ctrl
// Controller: sequences echo, erase and line replay one byte at a time.
// ============================================================================
module lede_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lede_pkg::status_type status,
   output lede_pkg::cmd_type    cmd
);

   lede_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lede_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.sel   = lede_pkg::SEL_RX;
      req_ready = 1'b0;
      case (state_ff)
         lede_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = lede_pkg::ST_DISPATCH;
            end
         end
         lede_pkg::ST_DISPATCH: begin
            if (status.halted) begin
               state_in = lede_pkg::ST_IDLE;
            end else if (status.is_erase) begin
               if (status.fill_zero) begin
                  state_in = lede_pkg::ST_IDLE;
               end else begin
                  cmd.erase = 1'b1;
                  state_in  = lede_pkg::ST_BS1;
               end
            end else if (status.is_cr) begin
               state_in = lede_pkg::ST_CR;
            end else if (status.is_end) begin
               state_in = lede_pkg::ST_ECHO_END;
            end else begin
               cmd.store = 1'b1;
               state_in  = lede_pkg::ST_ECHO_CHAR;
            end
         end
         lede_pkg::ST_BS1: begin
            cmd.sel = lede_pkg::SEL_BS;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = lede_pkg::ST_BS2;
            end
         end
         lede_pkg::ST_BS2: begin
            cmd.sel = lede_pkg::SEL_SPACE;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = lede_pkg::ST_BS3;
            end
         end
         lede_pkg::ST_BS3: begin
            cmd.sel  = lede_pkg::SEL_BS;
            cmd.last = 1'b1;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = lede_pkg::ST_IDLE;
            end
         end
         lede_pkg::ST_CR: begin
            cmd.sel = lede_pkg::SEL_CR;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = lede_pkg::ST_CR_LF;
            end
         end
         lede_pkg::ST_CR_LF, lede_pkg::ST_ECHO_END, lede_pkg::ST_ECHO_CHAR: begin
            // Last echo byte of the input. A line end, or a byte that fills the store,
            // either halts on a quit word or starts the replay of the stored line.
            cmd.sel = (state_ff == lede_pkg::ST_CR_LF) ? lede_pkg::SEL_LF
                                                       : lede_pkg::SEL_RX;
            if (state_ff == lede_pkg::ST_ECHO_CHAR && !status.fill_full) begin
               cmd.last = 1'b1;
               if (status.slot_free) begin
                  cmd.emit = 1'b1;
                  state_in = lede_pkg::ST_IDLE;
               end
            end else begin
               cmd.last = status.quit_match;
               cmd.quit = status.quit_match;
               if (status.slot_free) begin
                  cmd.emit = 1'b1;
                  if (status.quit_match) begin
                     cmd.halt       = 1'b1;
                     cmd.clear_line = 1'b1;
                     state_in       = lede_pkg::ST_IDLE;
                  end else begin
                     cmd.idx_clear = 1'b1;
                     state_in      = lede_pkg::ST_RD;
                  end
               end
            end
         end
         lede_pkg::ST_RD: begin
            if (status.idx_done) begin
               state_in = lede_pkg::ST_CRLF_CR;
            end else begin
               cmd.rd   = 1'b1;
               state_in = lede_pkg::ST_RD_EMIT;
            end
         end
         lede_pkg::ST_RD_EMIT: begin
            cmd.sel = lede_pkg::SEL_MEM;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = lede_pkg::ST_RD;
            end
         end
         lede_pkg::ST_CRLF_CR: begin
            cmd.sel = lede_pkg::SEL_CR;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = lede_pkg::ST_CRLF_LF;
            end
         end
         lede_pkg::ST_CRLF_LF: begin
            cmd.sel  = lede_pkg::SEL_LF;
            cmd.last = 1'b1;
            if (status.slot_free) begin
               cmd.emit       = 1'b1;
               cmd.clear_line = 1'b1;
               state_in       = lede_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lede_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/lede_dp.sv =====
// ============================================================================
// lede_dp
// Datapath: line store, fill count, quit-word match and output register.
// ============================================================================
module lede_dp #(
   parameter int LINE_LEN = lede_pkg::LINE_LEN_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [lede_pkg::BYTE_W-1:0]  rx_byte,
   input  lede_pkg::cmd_type            cmd,
   output lede_pkg::status_type         status,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [lede_pkg::BYTE_W-1:0]  tx_byte,
   output logic                         last,
   output logic                         quit_seen
);

   localparam int DEPTH  = LINE_LEN - 1;
   localparam int FILL_W = $clog2(LINE_LEN);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int HEAD_N = 4;

   logic [lede_pkg::BYTE_W-1:0] store_mem [DEPTH];
   logic [lede_pkg::BYTE_W-1:0] rd_data_ff;
   logic [lede_pkg::BYTE_W-1:0] rx_ff;
   logic [lede_pkg::BYTE_W-1:0] head_ff [HEAD_N];

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic              halted_ff, halted_in;
   logic              valid_ff, valid_in;
   logic [lede_pkg::BYTE_W-1:0] tx_ff, tx_in;
   logic              last_ff, last_in;
   logic              quit_ff, quit_in;

   logic is_quit, is_q, is_exit;

   // Line store: written at the fill position, read during replay.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         store_mem[fill_ff[IDX_W-1:0]] <= rx_ff;
      end
      if (cmd.rd) begin
         rd_data_ff <= store_mem[idx_ff[IDX_W-1:0]];
      end
   end

   // The first few bytes of the line are also kept in flops for the match.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rx_ff <= rx_byte;
      end
      if (cmd.store && fill_ff < FILL_W'(HEAD_N)) begin
         head_ff[fill_ff[1:0]] <= rx_ff;
      end
   end

   always_comb begin
      is_quit = fill_ff == FILL_W'(4) && head_ff[0] == lede_pkg::CHAR_Q &&
                head_ff[1] == lede_pkg::CHAR_U && head_ff[2] == lede_pkg::CHAR_I &&
                head_ff[3] == lede_pkg::CHAR_T;
      is_exit = fill_ff == FILL_W'(4) && head_ff[0] == lede_pkg::CHAR_E &&
                head_ff[1] == lede_pkg::CHAR_X && head_ff[2] == lede_pkg::CHAR_I &&
                head_ff[3] == lede_pkg::CHAR_T;
      is_q    = fill_ff == FILL_W'(1) && head_ff[0] == lede_pkg::CHAR_Q;
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear_line) begin
         fill_in = '0;
      end else if (cmd.store) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.erase) begin
         fill_in = fill_ff - 1'b1;
      end

      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.rd) begin
         idx_in = idx_ff + 1'b1;
      end

      halted_in = halted_ff | cmd.halt;

      valid_in = valid_ff;
      tx_in    = tx_ff;
      last_in  = last_ff;
      quit_in  = quit_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         last_in  = cmd.last;
         quit_in  = cmd.quit;
         case (cmd.sel)
            lede_pkg::SEL_BS:    tx_in = lede_pkg::CHAR_BS;
            lede_pkg::SEL_SPACE: tx_in = lede_pkg::CHAR_SPACE;
            lede_pkg::SEL_CR:    tx_in = lede_pkg::CHAR_CR;
            lede_pkg::SEL_LF:    tx_in = lede_pkg::CHAR_LF;
            lede_pkg::SEL_MEM:   tx_in = rd_data_ff;
            default:             tx_in = rx_ff;
         endcase
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         halted_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         halted_ff <= halted_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      tx_ff   <= tx_in;
      last_ff <= last_in;
      quit_ff <= quit_in;
   end

   always_comb begin
      status.is_erase   = rx_ff == lede_pkg::CHAR_DEL || rx_ff == lede_pkg::CHAR_BS;
      status.is_cr      = rx_ff == lede_pkg::CHAR_CR;
      status.is_end     = rx_ff == lede_pkg::CHAR_NUL || rx_ff == lede_pkg::CHAR_LF;
      status.fill_zero  = fill_ff == '0;
      status.fill_full  = fill_ff == FILL_W'(DEPTH);
      status.quit_match = is_quit || is_q || is_exit;
      status.idx_done   = idx_ff == fill_ff;
      status.halted     = halted_ff;
      status.slot_free  = !valid_ff || rsp_ready;
   end

   assign rsp_valid = valid_ff;
   assign tx_byte   = tx_ff;
   assign last      = last_ff;
   assign quit_seen = quit_ff;

   // A new word never overwrites one that is still waiting at the output.
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!valid_ff || rsp_ready))
      else $error("word emitted into a full output register");

   // Once halted, the block stays halted until reset.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag dropped");

   // The fill count never grows beyond the store depth.
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> fill_ff < FILL_W'(DEPTH))
      else $error("store write with a full line");

   // A quit mark only ever rides on the final word of an input.
   a_quit_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && quit_ff) |-> last_ff)
      else $error("quit mark without last mark");

endmodule

// ===== sv/line_editor_echo_with_quit_match.sv =====
// ============================================================================
// line_editor_echo_with_quit_match
// Terminal line editor that echoes received bytes and detects quit words.
// ============================================================================
// Each received byte takes one pass of the controller and yields zero or more
// transmit words, the final one marked with last. An ordinary byte is stored
// and echoed, an erase sends BS, space and BS, and an erase on an empty line
// or any byte after a halt sends nothing. A line end echoes itself (NUL or
// LF) or CR and LF (CR), then, unless the line is a quit word, replays each
// stored byte, reading it from the store and then emitting it, sees that the
// replay is done and sends a closing CR LF. A line that fills the store with
// LINE_LEN-1 bytes is the longest case. The replay pace is set by the line
// store's single registered read port, which fetches each byte into a read
// register before it enters the one-word output register. Each step that
// emits a word waits for a free output slot. A new byte is taken whenever
// the controller is idle, even while the last word of the previous byte
// still sits in the output register. After a line equal to "quit", "q" or
// "exit" the block marks quit_seen on its final echo word and then silently
// drops every further byte until reset.
// ============================================================================
module line_editor_echo_with_quit_match #(
   parameter int LINE_LEN = lede_pkg::LINE_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lede_req_if.sink    req_ch,
   lede_rsp_if.source  rsp_ch
);

   lede_pkg::cmd_type    cmd;
   lede_pkg::status_type status;

   // The controller decides which word goes out next; the datapath holds the
   // line, the counters and the output register.
   lede_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lede_dp #(
      .LINE_LEN (LINE_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .rx_byte   (req_ch.rx_byte),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .tx_byte   (rsp_ch.tx_byte),
      .last      (rsp_ch.last),
      .quit_seen (rsp_ch.quit_seen)
   );

endmodule
